### design/bdd_pkg.sv
package bdd_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int POS_W     = 16;
	localparam int DERIV_W   = 25;
	localparam int HALF_W    = 10;
	localparam int FRAC_BITS = 4;
	localparam int WEIGHT_W  = 11;
	localparam int TAPW_W    = FRAC_BITS + 1;
	localparam int SUM_W     = 30;
	localparam int DEPTH     = 128;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = 48;
	localparam int PROD_W    = SUM_W + WEIGHT_W + 1;
	localparam int DEN_W     = 2 * WEIGHT_W;
	localparam int DIV_W     = PROD_W + 1 + 9;
	localparam int DIVSR_W   = DEN_W + 1;
	localparam int STEP_W    = $clog2(DIV_W + 1);

	localparam logic [HALF_W-1:0] HALF_MIN   = HALF_W'(1 << FRAC_BITS);
	localparam logic [HALF_W-1:0] HALF_MAX   = HALF_W'(800);
	localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(40);
	localparam logic [TAPW_W-1:0] ONE_Q      = TAPW_W'(1 << FRAC_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SUM,
		ST_DRAIN,
		ST_START,
		ST_CALC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                       mem_we;
		logic [ADDR_W-1:0]          mem_waddr;
		logic                       rd_en;
		logic [ADDR_W-1:0]          rd_addr;
		logic                       rd_left;
		logic [TAPW_W-1:0]          rd_weight;
		logic                       clr_sums;
		logic                       calc_start;
		logic [WEIGHT_W-1:0]        rw;
		logic [WEIGHT_W-1:0]        lw;
		logic                       emit;
		logic [POS_W-1:0]           position;
		logic                       last_result;
	} cmd_t;

	typedef struct packed {
		logic calc_done;
		logic out_free;
	} status_t;

endpackage

### design/bdd_channels.sv
interface bdd_sample_if;
	import bdd_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_sample;
	modport source (output valid, sample, last_sample, input ready);
	modport sink (input valid, sample, last_sample, output ready);
endinterface

interface bdd_result_if;
	import bdd_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [POS_W-1:0]          position;
	logic signed [DERIV_W-1:0] derivative;
	logic                      last_result;
	logic                      weight_error;
	modport source (output valid, position, derivative, last_result, weight_error,
		input ready);
	modport sink (input valid, position, derivative, last_result, weight_error,
		output ready);
endinterface

### design/bdd_ctrl.sv
module bdd_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [bdd_pkg::HALF_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	input  logic                       in_last,
	output logic                       in_ready,
	input  bdd_pkg::status_t           status,
	output bdd_pkg::cmd_t              cmd
);
	import bdd_pkg::*;

	state_t state_q, state_d;
	logic [HALF_W-1:0]   h_q;
	logic [HALF_W-1:0]   hc;
	logic [CNT_W-1:0]    s;
	logic [FRAC_BITS-1:0] a;
	logic [CNT_W-1:0]    seen_q;
	logic [CNT_W-1:0]    i;
	logic [CNT_W-1:0]    x_q, x_end_q, p_q, k_q, k0_q, k1_q;
	logic                has_end_q, left_a_q, right_a_q;
	logic                xfer;
	logic                x_lt_s, tail;
	logic [CNT_W-1:0]    k0_d, k1_d, lw_full, rw_tail, w_frac;

	always_comb begin
		hc = h_q;
		if (h_q < HALF_MIN) hc = HALF_MIN;
		if (h_q > HALF_MAX) hc = HALF_MAX;
	end
	assign s = CNT_W'(hc >> FRAC_BITS);
	assign a = hc[FRAC_BITS-1:0];
	assign i = seen_q;
	assign in_ready = (state_q == ST_IDLE);
	assign xfer = in_valid && in_ready;

	assign x_lt_s  = x_q < s;
	assign tail    = has_end_q && (x_q + s >= p_q);
	assign k0_d    = x_lt_s ? '0 : x_q - s;
	assign k1_d    = tail ? p_q : x_q + s + CNT_W'(1);
	assign lw_full = (x_q + CNT_W'(1)) << FRAC_BITS;
	assign rw_tail = (p_q - x_q) << FRAC_BITS;
	assign w_frac  = (s << FRAC_BITS) + CNT_W'(a);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (xfer) begin
					if (in_last) begin
						if (i >= CNT_W'(1)) state_d = ST_SETUP;
					end else if (i >= s + CNT_W'(1)) begin
						state_d = ST_SETUP;
					end
				end
			end
			ST_SETUP: state_d = ST_SUM;
			ST_SUM:   if (k_q == k1_q) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_START;
			ST_START: state_d = ST_CALC;
			ST_CALC:  if (status.calc_done) state_d = ST_EMIT;
			ST_EMIT: begin
				if (status.out_free) begin
					state_d = (x_q + CNT_W'(1) == x_end_q) ? ST_IDLE : ST_SETUP;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mem_waddr = seen_q[ADDR_W-1:0];
		cmd.rd_addr   = k_q[ADDR_W-1:0];
		cmd.rd_left   = k_q <= x_q;
		cmd.rd_weight = ONE_Q;
		if (k_q == k0_q && left_a_q) cmd.rd_weight = TAPW_W'(a);
		if (k_q == k1_q && right_a_q) cmd.rd_weight = TAPW_W'(a);
		cmd.rw          = tail ? rw_tail[WEIGHT_W-1:0] : w_frac[WEIGHT_W-1:0];
		cmd.lw          = x_lt_s ? lw_full[WEIGHT_W-1:0] : w_frac[WEIGHT_W-1:0];
		cmd.position    = x_q[POS_W-1:0];
		cmd.last_result = has_end_q && (x_q + CNT_W'(1) == p_q);
		unique case (state_q)
			ST_IDLE:  cmd.mem_we = xfer;
			ST_SETUP: cmd.clr_sums = 1'b1;
			ST_SUM:   cmd.rd_en = 1'b1;
			ST_START: cmd.calc_start = 1'b1;
			ST_EMIT:  cmd.emit = status.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			h_q       <= HALF_RESET;
			seen_q    <= '0;
			x_q       <= '0;
			x_end_q   <= '0;
			p_q       <= '0;
			k_q       <= '0;
			k0_q      <= '0;
			k1_q      <= '0;
			has_end_q <= 1'b0;
			left_a_q  <= 1'b0;
			right_a_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) h_q <= cfg_wr_data;
			unique case (state_q)
				ST_IDLE: begin
					if (xfer) begin
						if (in_last) begin
							seen_q    <= '0;
							has_end_q <= 1'b1;
							p_q       <= i;
							x_end_q   <= i;
							x_q       <= (i >= s + CNT_W'(1)) ? i - s - CNT_W'(1) : '0;
						end else begin
							seen_q    <= seen_q + CNT_W'(1);
							has_end_q <= 1'b0;
							x_q       <= i - s - CNT_W'(1);
							x_end_q   <= i - s;
						end
					end
				end
				ST_SETUP: begin
					k_q       <= k0_d;
					k0_q      <= k0_d;
					k1_q      <= k1_d;
					left_a_q  <= !x_lt_s;
					right_a_q <= !tail;
				end
				ST_SUM: k_q <= k_q + CNT_W'(1);
				ST_EMIT: if (status.out_free) x_q <= x_q + CNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

### design/bdd_datapath.sv
module bdd_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bdd_pkg::cmd_t                     cmd,
	output bdd_pkg::status_t                  status,
	input  logic signed [bdd_pkg::SAMPLE_W-1:0] sample,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [bdd_pkg::POS_W-1:0]         position,
	output logic signed [bdd_pkg::DERIV_W-1:0] derivative,
	output logic                              last_result,
	output logic                              weight_error
);
	import bdd_pkg::*;

	logic signed [SAMPLE_W-1:0] mem_q [DEPTH];
	logic signed [SAMPLE_W-1:0] rd_data_s1;
	logic                       rd_valid_s1, rd_left_s1;
	logic [TAPW_W-1:0]          rd_weight_s1;
	logic signed [SUM_W-1:0]    ls_q, rs_q;
	logic signed [SUM_W-1:0]    tap;
	logic [WEIGHT_W-1:0]        rw_q, lw_q;

	logic [2:0]                 phase_q;
	logic signed [SUM_W-1:0]    op_a;
	logic [WEIGHT_W-1:0]        op_b;
	logic signed [PROD_W-1:0]   prod, prod_q, num1_q, num_q;
	logic [PROD_W-1:0]          mag;
	logic                       neg_q, err_q, busy_q, done_q;
	logic [DIV_W-1:0]           dvd_q;
	logic [DIVSR_W-1:0]         dvs_q, rem_q;
	logic [DIVSR_W:0]           trial;
	logic [STEP_W-1:0]          step_q;
	logic [DIV_W-1:0]           dvd_init;
	logic [DERIV_W-1:0]         qv;

	logic                       out_valid_q, last_q, err_out_q;
	logic [POS_W-1:0]           pos_q;
	logic signed [DERIV_W-1:0]  deriv_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_we) mem_q[cmd.mem_waddr] <= sample;
		if (cmd.rd_en) rd_data_s1 <= mem_q[cmd.rd_addr];
	end

	assign tap = SUM_W'(rd_data_s1 * $signed({1'b0, rd_weight_s1}));

	always_comb begin
		op_a = rs_q;
		op_b = lw_q;
		unique case (phase_q)
			3'd1: begin
				op_a = ls_q;
				op_b = rw_q;
			end
			3'd2: begin
				op_a = SUM_W'(rw_q);
				op_b = lw_q;
			end
			default: ;
		endcase
	end
	assign prod = PROD_W'(op_a * $signed({1'b0, op_b}));
	assign mag  = num_q[PROD_W-1] ? PROD_W'(-num_q) : PROD_W'(num_q);
	assign dvd_init = ({mag, 9'b0} | DIV_W'(0)) + DIV_W'(prod_q[DEN_W-1:0]);
	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign qv = dvd_q[DERIV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			phase_q     <= '0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			if (cmd.calc_start) begin
				phase_q <= 3'd1;
				done_q  <= 1'b0;
			end else if (phase_q == 3'd1) begin
				phase_q <= 3'd2;
			end else if (phase_q == 3'd2) begin
				phase_q <= 3'd3;
			end else if (phase_q == 3'd3) begin
				phase_q <= '0;
				if (err_q) done_q <= 1'b1;
				else busy_q <= 1'b1;
			end else if (busy_q && step_q == STEP_W'(DIV_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_left_s1   <= cmd.rd_left;
		rd_weight_s1 <= cmd.rd_weight;
		if (cmd.clr_sums) begin
			ls_q <= '0;
			rs_q <= '0;
			rw_q <= cmd.rw;
			lw_q <= cmd.lw;
		end else if (rd_valid_s1) begin
			if (rd_left_s1) ls_q <= ls_q + tap;
			else rs_q <= rs_q + tap;
		end
		if (cmd.calc_start) begin
			prod_q <= prod;
			err_q  <= (rw_q == '0) || (lw_q == '0);
		end else if (phase_q == 3'd1) begin
			num1_q <= prod_q;
			prod_q <= prod;
		end else if (phase_q == 3'd2) begin
			num_q  <= num1_q - prod_q;
			prod_q <= prod;
		end else if (phase_q == 3'd3) begin
			neg_q  <= num_q[PROD_W-1];
			dvd_q  <= dvd_init;
			dvs_q  <= {prod_q[DEN_W-1:0], 1'b0};
			rem_q  <= '0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= DIVSR_W'(trial - {1'b0, dvs_q});
				dvd_q <= {dvd_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIVSR_W-1:0];
				dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			end
		end
		if (cmd.emit) begin
			pos_q     <= cmd.position;
			last_q    <= cmd.last_result;
			err_out_q <= err_q;
			if (err_q) deriv_q <= '0;
			else deriv_q <= neg_q ? $signed(-qv) : $signed(qv);
		end
	end

	assign status.calc_done = done_q;
	assign status.out_free  = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign position     = pos_q;
	assign derivative   = deriv_q;
	assign last_result  = last_q;
	assign weight_error = err_out_q;

endmodule

### design/box_difference_derivative_unit.sv
// channel  | dir | payload
// samples  | in  | sample, last_sample
// results  | out | position, derivative, last_result, weight_error
// config   | in  | cfg_wr_en, cfg_wr_data (half_length_q4)
// a sample that yields no result leaves the unit ready for the next sample; each
// result is then read from the window memory, summed and multiplied, then divided
// in the one-bit-per-cycle restoring divider
// samples are taken only while no result is being computed; one may still wait to be taken
// a stalled result holds in the output register; reset clears control only
module box_difference_derivative_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [bdd_pkg::HALF_W-1:0] cfg_wr_data,
	bdd_sample_if.sink                 samples,
	bdd_result_if.source               results
);
	import bdd_pkg::*;

	cmd_t    cmd;
	status_t status;

	bdd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (samples.valid),
		.in_last     (samples.last_sample),
		.in_ready    (samples.ready),
		.status      (status),
		.cmd         (cmd)
	);

	bdd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sample       (samples.sample),
		.out_ready    (results.ready),
		.out_valid    (results.valid),
		.position     (results.position),
		.derivative   (results.derivative),
		.last_result  (results.last_result),
		.weight_error (results.weight_error)
	);

endmodule
